FILE: design/costmap_nearest_obstacle_search_macros.svh
// assertion macros for the costmap nearest obstacle search block
`ifndef COSTMAP_NEAREST_OBSTACLE_SEARCH_MACROS_SVH
`define COSTMAP_NEAREST_OBSTACLE_SEARCH_MACROS_SVH
`ifndef ASSERT_OFF
// checked outside reset
`define CNOS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define CNOS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CNOS_ASSERT(lbl, prop, msg)
`define CNOS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: design/cnos_pkg.sv
// shared constants and types for the costmap nearest obstacle search
package cnos_pkg;
    localparam int MAP_DIM    = 256;
    localparam int MAP_AW     = $clog2(MAP_DIM);
    localparam int MAP_CELLS  = MAP_DIM * MAP_DIM;
    localparam int MAX_RADIUS = 15;

    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t REG_MAP_WIDTH  = 3'd0;
    localparam cfg_idx_t REG_MAP_HEIGHT = 3'd1;
    localparam cfg_idx_t REG_RADIUS     = 3'd2;
    localparam cfg_idx_t REG_RESOLUTION = 3'd3;
    localparam cfg_idx_t REG_ORIGIN_X   = 3'd4;
    localparam cfg_idx_t REG_ORIGIN_Y   = 3'd5;
    localparam cfg_idx_t REG_THRESHOLD  = 3'd6;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [31:0] q16_t;
endpackage

FILE: design/costmap_nearest_obstacle_search.sv
// costmap nearest obstacle search: grid store, window scan, shared multiplier and sqrt
//
// channel   dir  handshake          payload
// in        in   in_valid/in_stall  cmd cell_x cell_y cell_value query_x query_y
// out       out  out_valid/out_stall distance found
// cfg       in   cfg_valid/cfg_ready cfg_index cfg_data
//
// a cell write gives no beat
// a query runs the divider for x then for y, visits each window cell (reading the store
// if inside the map), uses the shared multiplier per obstacle cell, then the square root;
// query time is set by the single memory read port and the multiplier
// in_stall is high for the whole query and while the result beat waits on out_stall
// reset clears control and the configuration registers; the grid store holds nothing useful until written
`include "costmap_nearest_obstacle_search_macros.svh"
module costmap_nearest_obstacle_search
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cmd,
    input  logic [7:0]           cell_x,
    input  logic [7:0]           cell_y,
    input  logic signed [7:0]    cell_value,
    input  logic signed [31:0]   query_x,
    input  logic signed [31:0]   query_y,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cnos_pkg::q16_t       distance,
    output logic                 found,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  cnos_pkg::cfg_idx_t   cfg_index,
    input  logic [31:0]          cfg_data
);
    import cnos_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_DFIN  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_MX    = 4'd5;
    localparam logic [3:0] S_MY    = 4'd6;
    localparam logic [3:0] S_QX    = 4'd7;
    localparam logic [3:0] S_QY    = 4'd8;
    localparam logic [3:0] S_CMP   = 4'd9;
    localparam logic [3:0] S_SQI   = 4'd10;
    localparam logic [3:0] S_SQRT  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    // configuration registers
    logic [8:0]  map_width_reg;
    logic [8:0]  map_height_reg;
    logic [3:0]  radius_reg;
    logic [31:0] res_reg;
    logic [31:0] origin_x_reg;
    logic [31:0] origin_y_reg;
    logic [6:0]  thr_reg;

    // control
    logic [3:0]  state_reg;
    logic [5:0]  cnt_reg;
    logic        axis_reg;
    logic        found_reg;
    logic signed [4:0] dx_reg;
    logic signed [4:0] dy_reg;

    // datapath
    logic signed [32:0] diffx_reg, diffy_reg;
    logic [32:0] num_reg;
    logic [31:0] rem_reg;
    logic        neg_reg;
    logic signed [34:0] cx_reg, cy_reg;
    logic [MAP_AW-1:0] mx_reg, my_reg;
    logic [7:0]  rd_data_reg;
    logic [65:0] prod_reg;
    logic [41:0] ax_reg, ay_reg;
    logic [63:0] qx_reg;
    logic [63:0] best_reg;
    logic [63:0] sq_n_reg, sq_r_reg, sq_bit_reg;

    logic [7:0] mem [0:MAP_CELLS-1];

    // effective limits
    logic [8:0] w_eff, h_eff;
    logic [3:0] rad_eff;
    logic signed [4:0] rad_s, rad_lo;
    always_comb
    begin
        w_eff   = (map_width_reg  > 9'(MAP_DIM)) ? 9'(MAP_DIM) : map_width_reg;
        h_eff   = (map_height_reg > 9'(MAP_DIM)) ? 9'(MAP_DIM) : map_height_reg;
        rad_eff = (radius_reg > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : radius_reg;
        rad_s   = $signed({1'b0, rad_eff});
        rad_lo  = -rad_s;
    end

    // query offsets from the grid corner
    logic signed [32:0] qdx, qdy;
    logic [32:0] qdx_abs, dy_abs;
    assign qdx     = {query_x[31], query_x} - $signed({origin_x_reg[31], origin_x_reg});
    assign qdy     = {query_y[31], query_y} - $signed({origin_y_reg[31], origin_y_reg});
    assign qdx_abs = qdx[32] ? 33'(-qdx) : 33'(qdx);
    assign dy_abs  = diffy_reg[32] ? 33'(-diffy_reg) : 33'(diffy_reg);

    // divider step and final floor
    logic [32:0] trial;
    logic        ge;
    logic [33:0] q_up;
    logic signed [34:0] c_val;
    always_comb
    begin
        trial = {rem_reg, num_reg[32]};
        ge    = trial >= {1'b0, res_reg};
        q_up  = {1'b0, num_reg} + 34'(rem_reg != 32'd0);
        c_val = neg_reg ? -$signed({1'b0, q_up}) : $signed({2'b00, num_reg});
    end

    // window cell position and bounds
    logic signed [35:0] mx_s, my_s;
    logic in_map, last_x, last_cell, obstacle;
    always_comb
    begin
        mx_s      = {cx_reg[34], cx_reg} + 36'(dx_reg);
        my_s      = {cy_reg[34], cy_reg} + 36'(dy_reg);
        in_map    = !mx_s[35] && !my_s[35] && (mx_s < $signed({27'd0, w_eff}))
                    && (my_s < $signed({27'd0, h_eff}));
        last_x    = dx_reg == rad_s;
        last_cell = last_x && (dy_reg == rad_s);
        obstacle  = !rd_data_reg[7] && (rd_data_reg[6:0] > thr_reg);
    end

    // shared multiplier operands
    logic [32:0] mul_a, mul_b;
    always_comb
    begin
        case (state_reg)
            S_MX:
            begin
                mul_a = 33'({mx_reg, 1'b1});
                mul_b = {1'b0, res_reg};
            end
            S_MY:
            begin
                mul_a = 33'({my_reg, 1'b1});
                mul_b = {1'b0, res_reg};
            end
            S_QX:
            begin
                mul_a = {1'b0, ax_reg[32:1]};
                mul_b = 33'(ax_reg[32:1]) + 33'(ax_reg[0]);
            end
            default:
            begin
                mul_a = {1'b0, ay_reg[32:1]};
                mul_b = 33'(ay_reg[32:1]) + 33'(ay_reg[0]);
            end
        endcase
    end

    // doubled centre offset, absolute value
    logic signed [42:0] off_x, off_y;
    logic [41:0] off_abs;
    always_comb
    begin
        off_x   = {{9{diffx_reg[32]}}, diffx_reg, 1'b0} - $signed({1'b0, prod_reg[41:0]});
        off_y   = {{9{diffy_reg[32]}}, diffy_reg, 1'b0} - $signed({1'b0, prod_reg[41:0]});
        off_abs = (state_reg == S_MY) ? (off_x[42] ? 42'(-off_x) : 42'(off_x))
                                      : (off_y[42] ? 42'(-off_y) : 42'(off_y));
    end

    // squared distance with saturation
    logic [64:0] sq_sum;
    logic [63:0] t_val;
    always_comb
    begin
        sq_sum = {1'b0, qx_reg} + {1'b0, prod_reg[63:0]};
        t_val  = (ax_reg[41:33] == 9'd0 && ay_reg[41:33] == 9'd0 && !sq_sum[64])
                 ? sq_sum[63:0] : '1;
    end

    // square root step
    logic [63:0] sq_try;
    assign sq_try = sq_r_reg + sq_bit_reg;

    // grid store
    logic accept_in;
    assign accept_in = in_valid && !in_stall;
    always_ff @(posedge clk)
    begin
        if (accept_in && cmd == CMD_WRITE)
        begin
            mem[{cell_y, cell_x}] <= cell_value;
        end
        rd_data_reg <= mem[{my_s[MAP_AW-1:0], mx_s[MAP_AW-1:0]}];
    end

    // configuration writes
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= 9'd256;
            map_height_reg <= 9'd256;
            radius_reg     <= 4'd3;
            res_reg        <= 32'd3277;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            thr_reg        <= 7'd65;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAP_WIDTH:  map_width_reg  <= cfg_data[8:0];
                REG_MAP_HEIGHT: map_height_reg <= cfg_data[8:0];
                REG_RADIUS:     radius_reg     <= cfg_data[3:0];
                REG_RESOLUTION: res_reg        <= cfg_data;
                REG_ORIGIN_X:   origin_x_reg   <= cfg_data;
                REG_ORIGIN_Y:   origin_y_reg   <= cfg_data;
                REG_THRESHOLD:  thr_reg        <= cfg_data[6:0];
                default:        ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= 1'b0;
            found_reg <= 1'b0;
            dx_reg    <= '0;
            dy_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept_in && cmd == CMD_QUERY)
                    begin
                        found_reg <= 1'b0;
                        axis_reg  <= 1'b0;
                        cnt_reg   <= 6'd32;
                        state_reg <= (res_reg == 32'd0) ? S_OUT : S_DIV;
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= S_DFIN;
                    end
                end
                S_DFIN:
                begin
                    if (!axis_reg)
                    begin
                        axis_reg  <= 1'b1;
                        cnt_reg   <= 6'd32;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        dx_reg    <= rad_lo;
                        dy_reg    <= rad_lo;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN, S_CHECK, S_CMP:
                begin
                    if (state_reg == S_SCAN && in_map)
                    begin
                        state_reg <= S_CHECK;
                    end
                    else if (state_reg == S_CHECK && obstacle)
                    begin
                        found_reg <= 1'b1;
                        state_reg <= S_MX;
                    end
                    else
                    begin
                        // step to the next window cell
                        state_reg <= last_cell ? S_SQI : S_SCAN;
                        if (last_x)
                        begin
                            dx_reg <= rad_lo;
                            dy_reg <= dy_reg + 5'sd1;
                        end
                        else
                        begin
                            dx_reg <= dx_reg + 5'sd1;
                        end
                    end
                end
                S_MX: state_reg <= S_MY;
                S_MY: state_reg <= S_QX;
                S_QX: state_reg <= S_QY;
                S_QY: state_reg <= S_CMP;
                S_SQI:
                begin
                    cnt_reg   <= 6'd31;
                    state_reg <= found_reg ? S_SQRT : S_OUT;
                end
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                diffx_reg <= qdx;
                diffy_reg <= qdy;
                num_reg   <= qdx_abs;
                neg_reg   <= qdx[32];
                rem_reg   <= '0;
            end
            S_DIV:
            begin
                num_reg <= {num_reg[31:0], ge};
                rem_reg <= ge ? 32'(trial - {1'b0, res_reg}) : trial[31:0];
            end
            S_DFIN:
            begin
                if (!axis_reg)
                begin
                    cx_reg  <= c_val;
                    num_reg <= dy_abs;
                    neg_reg <= diffy_reg[32];
                    rem_reg <= '0;
                end
                else
                begin
                    cy_reg   <= c_val;
                    best_reg <= '1;
                end
            end
            S_SCAN:
            begin
                mx_reg <= mx_s[MAP_AW-1:0];
                my_reg <= my_s[MAP_AW-1:0];
            end
            S_MX: prod_reg <= mul_a * mul_b;
            S_MY:
            begin
                ax_reg   <= off_abs;
                prod_reg <= mul_a * mul_b;
            end
            S_QX:
            begin
                ay_reg   <= off_abs;
                prod_reg <= mul_a * mul_b;
            end
            S_QY:
            begin
                qx_reg   <= prod_reg[63:0];
                prod_reg <= mul_a * mul_b;
            end
            S_CMP:
            begin
                if (t_val < best_reg)
                begin
                    best_reg <= t_val;
                end
            end
            S_SQI:
            begin
                sq_n_reg   <= best_reg;
                sq_r_reg   <= '0;
                sq_bit_reg <= 64'h4000_0000_0000_0000;
            end
            S_SQRT:
            begin
                if (sq_n_reg >= sq_try)
                begin
                    sq_n_reg <= sq_n_reg - sq_try;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            default: ;
        endcase
    end

    // ports
    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign found     = found_reg;
    assign distance  = found_reg ? sq_r_reg[31:0] : '1;

    // checks
    `CNOS_ASSERT(a_none_all_ones, (out_valid && !found) |-> (distance == 32'hFFFF_FFFF), "no obstacle but distance not saturated")
    `CNOS_ASSERT(a_window_bounds, (state_reg == S_SCAN) |-> (dx_reg >= rad_lo && dx_reg <= rad_s && dy_reg >= rad_lo && dy_reg <= rad_s), "scan position left the window")
    `CNOS_ASSERT(a_result_held, (out_valid && out_stall) |=> (out_valid && $stable(distance) && $stable(found)), "result beat changed while stalled")
    `CNOS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!out_valid && !in_stall), "block busy during reset")
endmodule

FILE: sim/costmap_nearest_obstacle_search_tb.sv
// self-checking testbench for the costmap nearest obstacle search block
`timescale 1ns / 100ps

module costmap_nearest_obstacle_search_tb;
    import cnos_pkg::*;

    localparam int QUIET_LIMIT = 50000;
    localparam int HOLD_CYCLES = 3000;
    // written corner blocks of the grid: low block and high block
    localparam int LOW_SPAN    = 32;
    localparam int HIGH_BASE   = 240;
    localparam int HIGH_SPAN   = 16;
    localparam int PHASE_ITEMS = 18;

    typedef struct packed {
        logic               cmd;
        logic [7:0]         cx;
        logic [7:0]         cy;
        logic signed [7:0]  value;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
    } grid_op_t;

    typedef struct packed {
        q16_t distance;
        logic found;
    } proximity_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               cmd = CMD_WRITE;
    logic [7:0]         cell_x = '0;
    logic [7:0]         cell_y = '0;
    logic signed [7:0]  cell_value = '0;
    logic signed [31:0] query_x = '0;
    logic signed [31:0] query_y = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    q16_t               distance;
    logic               found;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    cfg_idx_t           cfg_index = REG_MAP_WIDTH;
    logic [31:0]        cfg_data = '0;

    // shadow of the block's grid and registers
    logic [7:0]         grid [MAP_CELLS];
    logic [8:0]         map_w = 9'd256;
    logic [8:0]         map_h = 9'd256;
    logic [3:0]         radius = 4'd3;
    logic [31:0]        cell_size = 32'd3277;
    logic signed [31:0] org_x = '0;
    logic signed [31:0] org_y = '0;
    logic [6:0]         threshold = 7'd65;

    grid_op_t   grid_ops [$];
    proximity_t pending_distances [$];
    int         ops_pushed = 0;
    int         ops_taken = 0;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         hold_reqs = 0;
    int         errors = 0;

    costmap_nearest_obstacle_search i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_value (cell_value),
        .query_x    (query_x),
        .query_y    (query_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .distance   (distance),
        .found      (found),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // floored integer square root
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // floor(a*a/4) without overflow
    function automatic longint unsigned quarter_sq(longint unsigned a);
        longint unsigned hh;
        hh = a >> 1;
        return hh * hh + hh * (a & 64'd1);
    endfunction

    function automatic longint floor_div(longint num, longint den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    // nearest obstacle centre in the window around the query cell
    function automatic proximity_t nearest_obstacle(logic signed [31:0] qx,
                                                   logic signed [31:0] qy);
        proximity_t      res;
        longint          w, h, rad, cs, diffx, diffy, ccx, ccy, mx, my, ox2, oy2;
        longint unsigned ax, ay, sx, sy, t, best;
        logic [7:0]      raw;
        bit              hit;
        res.distance = 32'hFFFF_FFFF;
        res.found = 1'b0;
        if (cell_size == 0)
            return res;
        w = (map_w < MAP_DIM) ? map_w : MAP_DIM;
        h = (map_h < MAP_DIM) ? map_h : MAP_DIM;
        rad = (radius < MAX_RADIUS) ? radius : MAX_RADIUS;
        cs = longint'(cell_size);
        diffx = longint'(qx) - longint'(org_x);
        diffy = longint'(qy) - longint'(org_y);
        ccx = floor_div(diffx, cs);
        ccy = floor_div(diffy, cs);
        hit = 1'b0;
        best = '1;
        for (longint dy = -rad; dy <= rad; dy++)
        begin
            my = ccy + dy;
            if (my < 0 || my >= h)
                continue;
            for (longint dx = -rad; dx <= rad; dx++)
            begin
                mx = ccx + dx;
                if (mx < 0 || mx >= w)
                    continue;
                raw = grid[my * MAP_DIM + mx];
                if (raw[7] || raw[6:0] <= threshold)
                    continue;
                hit = 1'b1;
                ox2 = 2 * diffx - (2 * mx + 1) * cs;
                oy2 = 2 * diffy - (2 * my + 1) * cs;
                ax = (ox2 < 0) ? -ox2 : ox2;
                ay = (oy2 < 0) ? -oy2 : oy2;
                t = '1;
                if (ax < (64'd1 << 33) && ay < (64'd1 << 33))
                begin
                    sx = quarter_sq(ax);
                    sy = quarter_sq(ay);
                    if (sx <= ~64'd0 - sy)
                        t = sx + sy;
                end
                if (t < best)
                    best = t;
            end
        end
        if (hit)
        begin
            t = floor_sqrt(best);
            res.distance = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
            res.found = 1'b1;
        end
        return res;
    endfunction

    // input driver: takes beats off the op queue and predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        grid_op_t op;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                ops_taken++;
                if (cmd == CMD_WRITE)
                    grid[{cell_y, cell_x}] = cell_value;
                else
                    pending_distances = {pending_distances,
                                         nearest_obstacle(query_x, query_y)};
            end
            if (!in_valid || !in_stall)
            begin
                if (grid_ops.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    op = grid_ops.pop_front();
                    in_valid   <= 1'b1;
                    cmd        <= op.cmd;
                    cell_x     <= op.cx;
                    cell_y     <= op.cy;
                    cell_value <= op.value;
                    query_x    <= op.qx;
                    query_y    <= op.qy;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        proximity_t exp_r;
        int hold_seen;
        int hold_left;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_seen = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_distances.size() == 0)
                begin
                    $display("%0t: unexpected result beat distance %h found %b",
                             $time, distance, found);
                    errors++;
                end
                else
                begin
                    exp_r = pending_distances.pop_front();
                    if (distance !== exp_r.distance)
                    begin
                        $display("%0t: distance expected %h actual %h",
                                 $time, exp_r.distance, distance);
                        errors++;
                    end
                    if (found !== exp_r.found)
                    begin
                        $display("%0t: found expected %b actual %b",
                                 $time, exp_r.found, found);
                        errors++;
                    end
                end
            end
            if (hold_seen != hold_reqs)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        int quiet;
        if (!rst_n)
            quiet = 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic push_op(logic c, logic [7:0] x, logic [7:0] y, logic [7:0] v,
                           logic [31:0] qx, logic [31:0] qy);
        grid_op_t op;
        op.cmd = c;
        op.cx = x;
        op.cy = y;
        op.value = v;
        op.qx = qx;
        op.qy = qy;
        grid_ops = {grid_ops, op};
        ops_pushed++;
    endtask

    task automatic push_write(logic [7:0] x, logic [7:0] y, logic [7:0] v);
        push_op(CMD_WRITE, x, y, v, $urandom, $urandom);
    endtask

    task automatic push_query(logic [31:0] qx, logic [31:0] qy);
        push_op(CMD_QUERY, 8'($urandom), 8'($urandom), 8'($urandom), qx, qy);
    endtask

    // world coordinate somewhere inside the given column or row
    function automatic logic [31:0] aim(int idx, logic signed [31:0] org);
        longint v;
        if (cell_size == 0)
            return $urandom;
        v = longint'(org) + longint'(idx) * longint'(cell_size) +
            longint'($urandom % cell_size);
        if (v > 64'sd2147483647 || v < -64'sd2147483648)
            return $urandom;
        return v[31:0];
    endfunction

    // wait until all beats are through and the block has settled
    task automatic drain();
        do
            @(negedge clk);
        while (ops_taken != ops_pushed || pending_distances.size() != 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MAP_WIDTH:  map_w = val[8:0];
            REG_MAP_HEIGHT: map_h = val[8:0];
            REG_RADIUS:     radius = val[3:0];
            REG_RESOLUTION: cell_size = val;
            REG_ORIGIN_X:   org_x = val;
            REG_ORIGIN_Y:   org_y = val;
            REG_THRESHOLD:  threshold = val[6:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic random_cell_value(output logic [7:0] v);
        int pick;
        pick = $urandom_range(99);
        if (pick < 12)
            v = 8'($urandom_range(128, 255));
        else if (pick < 30)
            v = 8'($urandom_range(66, 127));
        else
            v = 8'($urandom_range(0, 65));
    endtask

    // stimulus
    initial
    begin
        logic [7:0] v;
        int w, h, col, row;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every cell a query window can reach is written once: both corner blocks
        for (int i = 0; i < LOW_SPAN * LOW_SPAN; i++)
        begin
            random_cell_value(v);
            push_write(8'(i % LOW_SPAN), 8'(i / LOW_SPAN), v);
        end
        for (int i = 0; i < HIGH_SPAN * HIGH_SPAN; i++)
        begin
            random_cell_value(v);
            push_write(8'(HIGH_BASE + i % HIGH_SPAN), 8'(HIGH_BASE + i / HIGH_SPAN), v);
        end
        drain();

        // directed: extremes of the fields at reset settings
        push_write(8'd0, 8'd0, 8'h80);
        push_write(8'd1, 8'd0, 8'd127);
        push_write(8'd2, 8'd0, 8'd0);
        push_write(8'd255, 8'd255, 8'd127);
        push_query(32'd0, 32'd0);
        push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_query(32'h8000_0000, 32'h8000_0000);
        push_query(32'h8000_0000, 32'd100);
        push_query(32'd255 * 3277 + 100, 32'd255 * 3277 + 3276);
        push_query(32'd3277, 32'd0);
        drain();
        // threshold extremes, radius extremes
        write_reg(REG_THRESHOLD, 32'd0);
        push_query(32'd5000, 32'd7000);
        drain();
        write_reg(REG_THRESHOLD, 32'd127);
        push_query(32'd5000, 32'd7000);
        drain();
        write_reg(REG_THRESHOLD, 32'd65);
        write_reg(REG_RADIUS, 32'd0);
        push_query(32'd3277, 32'd100);
        drain();
        write_reg(REG_RADIUS, 32'd15);
        push_query(32'd40000, 32'd40000);
        drain();
        write_reg(REG_RADIUS, 32'd3);
        // empty map and map size above storage
        write_reg(REG_MAP_WIDTH, 32'd0);
        push_query(32'd10000, 32'd10000);
        drain();
        write_reg(REG_MAP_WIDTH, 32'd511);
        write_reg(REG_MAP_HEIGHT, 32'd511);
        push_query(32'd255 * 3277, 32'd254 * 3277);
        drain();
        // zero resolution, then the widest and finest cells
        write_reg(REG_RESOLUTION, 32'd0);
        push_query(32'd0, 32'd0);
        drain();
        write_reg(REG_RESOLUTION, 32'hFFFF_FFFF);
        write_reg(REG_ORIGIN_X, 32'h8000_0000);
        write_reg(REG_ORIGIN_Y, 32'h8000_0000);
        write_reg(REG_RADIUS, 32'd2);
        push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_query(32'h8000_0000, 32'h0000_0000);
        drain();
        write_reg(REG_RESOLUTION, 32'd1);
        write_reg(REG_ORIGIN_X, 32'h7FFF_FFFF);
        write_reg(REG_ORIGIN_Y, 32'd0);
        push_query(32'h7FFF_FFFF, 32'd3);
        push_query(32'h8000_0000, 32'd3);
        drain();

        // random phases across settings and idling patterns, map kept in the low block
        for (int ph = 0; ph < 12; ph++)
        begin
            int pick;
            pick = $urandom_range(9);
            write_reg(REG_MAP_WIDTH, pick == 0 ? 32'(LOW_SPAN) :
                      $urandom_range(1, LOW_SPAN));
            pick = $urandom_range(9);
            write_reg(REG_MAP_HEIGHT, pick == 0 ? 32'(LOW_SPAN) :
                      $urandom_range(1, LOW_SPAN));
            pick = $urandom_range(9);
            write_reg(REG_RADIUS, pick == 0 ? 32'd15 : pick == 1 ? 32'd0 :
                      $urandom_range(1, 4));
            pick = $urandom_range(9);
            write_reg(REG_RESOLUTION, pick == 0 ? 32'd1 : pick == 1 ? 32'hFFFF_FFFF :
                      $urandom_range(32'h1000, 32'h40000));
            pick = $urandom_range(9);
            write_reg(REG_ORIGIN_X, pick == 0 ? $urandom :
                      $urandom_range(0, 32'h0100_0000) - 32'h0080_0000);
            pick = $urandom_range(9);
            write_reg(REG_ORIGIN_Y, pick == 0 ? $urandom :
                      $urandom_range(0, 32'h0100_0000) - 32'h0080_0000);
            write_reg(REG_THRESHOLD, $urandom_range(0, 127));

            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 81; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 81; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase

            w = (map_w < MAP_DIM) ? map_w : MAP_DIM;
            h = (map_h < MAP_DIM) ? map_h : MAP_DIM;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                begin
                    random_cell_value(v);
                    push_write(8'($urandom), 8'($urandom), v);
                end
                else if (pick < 38)
                    push_query($urandom, $urandom);
                else
                begin
                    col = $urandom_range(0, w + 1) - 1;
                    row = $urandom_range(0, h + 1) - 1;
                    push_query(aim(col, org_x), aim(row, org_y));
                end
            end
            // long receiver hold-off while the sender keeps offering
            if (ph == 0)
                hold_reqs++;
            drain();
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
